// ===== design/lfpa_pkg.sv =====
`timescale 1ns / 1ps

package lfpa_pkg;

	// Widths of the bus fields and registers.
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = 16;
	localparam int RPP_W   = 5;
	localparam int CFG_IDX_W = 2;

	// Frame sync byte, sent twice at the start of every frame.
	localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h59;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STRENGTH       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READINGS_PER_POINT = 2'd2;

	// Configuration register values after reset.
	localparam logic [DATA_W-1:0] MIN_STRENGTH_RST = 16'd100;
	localparam logic [DATA_W-1:0] MAX_DISTANCE_RST = 16'd800;
	localparam logic [RPP_W-1:0]  RPP_RST          = 5'd3;

	// Byte positions within a frame.
	localparam int POS_W = 4;
	typedef logic [POS_W-1:0] frame_pos_t;
	localparam frame_pos_t POS_HUNT1   = 4'd0;
	localparam frame_pos_t POS_HUNT2   = 4'd1;
	localparam frame_pos_t POS_DIST_LO = 4'd2;
	localparam frame_pos_t POS_DIST_HI = 4'd3;
	localparam frame_pos_t POS_STR_LO  = 4'd4;
	localparam frame_pos_t POS_STR_HI  = 4'd5;
	localparam frame_pos_t POS_CHECK   = 4'd8;

endpackage

// ===== design/lidar_frame_parse_and_average.sv =====
`timescale 1ns / 1ps

// Rangefinder frame parser with per-point averaging.
// Input channel (in_valid/in_ready/rx_byte): one received serial byte per beat.
// The parser hunts for two sync bytes, collects seven more and checks the
// 8-bit sum. Frames with a bad sum are dropped without a trace.
// Every passing frame is one reading; after readings_per_point readings one
// result beat leaves on the output channel (out_valid/out_ready) carrying the
// truncated mean distance and strength of the good readings and point_valid.
// A byte that does not close a group yields no beat.
// A byte that closes a group with good readings starts one shared restoring
// divider, one quotient bit per cycle: two divisions of SUM_W bits each, the
// distance sum and then the strength sum, into the result registers. A group
// without good readings skips the divider and holds a zero result. in_ready
// stays low while the divider runs and while a new result waits for a full
// output register; a stalled receiver therefore stops input only once a second
// result is ready. Configuration writes (cfg_we) take effect at once. Reset
// restores the register defaults and restarts the hunt.
module lidar_frame_parse_and_average #(
	parameter int MAX_READINGS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lfpa_pkg::BYTE_W-1:0]          rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lfpa_pkg::DATA_W-1:0]          mean_distance,
	output logic [lfpa_pkg::DATA_W-1:0]          mean_strength,
	output logic                                 point_valid,
	input  logic                                 cfg_we,
	input  logic [lfpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfpa_pkg::DATA_W-1:0]          cfg_data
);
	import lfpa_pkg::*;

	localparam int CNT_W = $clog2(MAX_READINGS + 1);
	localparam int SUM_W = $clog2(MAX_READINGS * 65535 + 1);
	localparam int BIT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		S_BYTE,
		S_DIV,
		S_HOLD
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] min_str_q;
	logic [DATA_W-1:0] max_dist_q;
	logic [RPP_W-1:0]  rpp_q;

	frame_pos_t        pos_q;
	logic [BYTE_W-1:0] csum_q;
	logic [DATA_W-1:0] dist_q;
	logic [DATA_W-1:0] str_q;
	logic [CNT_W-1:0]  readings_q;
	logic [CNT_W-1:0]  good_q;
	logic [SUM_W-1:0]  dsum_q;
	logic [SUM_W-1:0]  ssum_q;

	logic [SUM_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [BIT_W-1:0]  bit_q;
	logic              sel_str_q;

	logic [DATA_W-1:0] res_dist_q;
	logic [DATA_W-1:0] res_str_q;
	logic              res_valid_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_dist_q;
	logic [DATA_W-1:0] out_str_q;
	logic              out_pv_q;

	logic              accept;
	logic [RPP_W+CNT_W-1:0] rpp_ext;
	logic [CNT_W-1:0]  gsize;
	logic              good;
	logic [CNT_W-1:0]  readings_inc;
	logic              closing;
	logic [CNT_W-1:0]  good_next;
	logic [SUM_W-1:0]  dsum_next;
	logic [SUM_W-1:0]  ssum_next;
	logic [CNT_W:0]    rem_shift;
	logic              q_bit;
	logic [CNT_W:0]    rem_diff;
	logic [SUM_W-1:0]  quot;
	logic              out_free;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_BYTE);
	assign out_free = !out_valid_q || out_ready;

	// Group size: zero counts as one, anything above the limit saturates.
	assign rpp_ext = (RPP_W + CNT_W)'(rpp_q);
	always_comb begin
		if (rpp_q == '0) begin
			gsize = CNT_W'(1);
		end else if (rpp_ext > (RPP_W + CNT_W)'(MAX_READINGS)) begin
			gsize = CNT_W'(MAX_READINGS);
		end else begin
			gsize = rpp_ext[CNT_W-1:0];
		end
	end

	// Reading qualification and the accumulator values after this reading.
	assign good = (dist_q != '0) && (dist_q <= max_dist_q) && (str_q >= min_str_q);
	assign readings_inc = readings_q + CNT_W'(1);
	assign closing = (readings_inc >= gsize);
	assign good_next = good ? good_q + CNT_W'(1) : good_q;
	assign dsum_next = good ? dsum_q + SUM_W'(dist_q) : dsum_q;
	assign ssum_next = good ? ssum_q + SUM_W'(str_q) : ssum_q;

	// One restoring division step: shift in the next dividend bit, try to subtract.
	assign rem_shift = {rem_q, div_q[SUM_W-1]};
	assign q_bit = (rem_shift >= {1'b0, good_q});
	assign rem_diff = q_bit ? rem_shift - {1'b0, good_q} : rem_shift;
	assign quot = {div_q[SUM_W-2:0], q_bit};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_str_q <= MIN_STRENGTH_RST;
			max_dist_q <= MAX_DISTANCE_RST;
			rpp_q <= RPP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_STRENGTH: min_str_q <= cfg_data;
				REG_MAX_DISTANCE: max_dist_q <= cfg_data;
				REG_READINGS_PER_POINT: rpp_q <= cfg_data[RPP_W-1:0];
				default: ;
			endcase
		end
	end

	// Parser, accumulators, divider sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BYTE;
			pos_q <= POS_HUNT1;
			csum_q <= '0;
			dist_q <= '0;
			str_q <= '0;
			readings_q <= '0;
			good_q <= '0;
			dsum_q <= '0;
			ssum_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			sel_str_q <= 1'b0;
			res_dist_q <= '0;
			res_str_q <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_dist_q <= '0;
			out_str_q <= '0;
			out_pv_q <= 1'b0;
		end else begin
			// The receiver takes the pending beat; in S_HOLD the next result refills it.
			if (out_valid_q && out_ready && state_q != S_HOLD) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_BYTE: begin
					if (accept) begin
						unique case (pos_q)
							POS_HUNT1: begin
								if (rx_byte == HEADER_BYTE) begin
									csum_q <= rx_byte;
									pos_q <= POS_HUNT2;
								end
							end
							POS_HUNT2: begin
								if (rx_byte == HEADER_BYTE) begin
									csum_q <= csum_q + rx_byte;
									pos_q <= POS_DIST_LO;
								end else begin
									pos_q <= POS_HUNT1;
								end
							end
							POS_CHECK: begin
								pos_q <= POS_HUNT1;
								if (rx_byte == csum_q) begin
									good_q <= good_next;
									dsum_q <= dsum_next;
									ssum_q <= ssum_next;
									if (closing) begin
										readings_q <= '0;
										if (good_next != '0) begin
											div_q <= dsum_next;
											rem_q <= '0;
											bit_q <= '0;
											sel_str_q <= 1'b0;
											state_q <= S_DIV;
										end else begin
											res_dist_q <= '0;
											res_str_q <= '0;
											res_valid_q <= 1'b0;
											state_q <= S_HOLD;
										end
									end else begin
										readings_q <= readings_inc;
									end
								end
							end
							default: begin
								csum_q <= csum_q + rx_byte;
								if (pos_q == POS_DIST_LO) begin
									dist_q <= {8'h00, rx_byte};
								end else if (pos_q == POS_DIST_HI) begin
									dist_q[15:8] <= rx_byte;
								end else if (pos_q == POS_STR_LO) begin
									str_q <= {8'h00, rx_byte};
								end else if (pos_q == POS_STR_HI) begin
									str_q[15:8] <= rx_byte;
								end
								pos_q <= (pos_q < POS_CHECK) ? pos_q + POS_W'(1) : POS_HUNT1;
							end
						endcase
					end
				end

				// Distance sum first, then strength sum, through the same divider.
				S_DIV: begin
					div_q <= quot;
					rem_q <= rem_diff[CNT_W-1:0];
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(SUM_W - 1)) begin
						bit_q <= '0;
						rem_q <= '0;
						if (!sel_str_q) begin
							res_dist_q <= quot[DATA_W-1:0];
							div_q <= ssum_q;
							sel_str_q <= 1'b1;
						end else begin
							res_str_q <= quot[DATA_W-1:0];
							res_valid_q <= 1'b1;
							state_q <= S_HOLD;
						end
					end
				end

				// Move the result into the output register once it is free.
				S_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_dist_q <= res_dist_q;
						out_str_q <= res_str_q;
						out_pv_q <= res_valid_q;
						good_q <= '0;
						dsum_q <= '0;
						ssum_q <= '0;
						state_q <= S_BYTE;
					end
				end

				default: state_q <= S_BYTE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mean_distance = out_dist_q;
	assign mean_strength = out_str_q;
	assign point_valid = out_pv_q;

`ifndef SYNTH
	// The divider never runs with a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (good_q != '0))
		else $error("divider started with no good readings");

	// Between groups, good readings never outnumber the readings taken.
	a_good_le_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BYTE) |-> (good_q <= readings_q))
		else $error("good count exceeds readings taken");

	// A point without good readings carries zero means.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pv_q) |-> (out_dist_q == '0 && out_str_q == '0))
		else $error("invalid point carries nonzero means");

	// A pending result beat is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_dist_q)
			&& $stable(out_str_q) && $stable(out_pv_q)))
		else $error("pending result changed while stalled");

	// The frame position never leaves the frame.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CHECK)
		else $error("frame position out of range");
`endif

endmodule
